>>> hdl/asc_pkg.sv
// Shared types, constants and helper functions of the alignment identity scorer.
`default_nettype none
package asc_pkg;

  localparam int CNT_W      = 24;
  localparam int FIELD_W    = 24;
  localparam int GAP_W      = 24;
  localparam int BASE_W     = 8;
  localparam int MG_W       = 7;
  localparam int ID_W       = 12;
  localparam int THR_W      = MG_W + 4;
  localparam int SUM_W      = ((CNT_W > GAP_W) ? CNT_W : GAP_W) + 1;
  localparam int GOOD_W     = CNT_W + 1;
  localparam int TOTAL_W    = CNT_W + 2;
  localparam int GAPS_W     = CNT_W + 1;
  localparam int DIFF_W     = CNT_W + 3;
  localparam int SCALE_W    = 11;
  localparam int PROD_W     = DIFF_W + SCALE_W - 1;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;

  localparam logic [ADDR_W-1:0] ADDR_MIN_GOOD = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_CDNA     = ADDR_W'(4);

  localparam logic [MG_W-1:0] MIN_GOOD_RESET = MG_W'(90);

  localparam logic [CNT_W-1:0]         CNT_MAX       = '1;
  localparam logic [BASE_W-1:0]        BASE_UNKNOWN  = 8'h6E;
  localparam logic signed [SCALE_W-1:0] ID_SCALE     = 11'sd1000;
  localparam logic [NUM_W-1:0]         ID_HIGH_MAG   = NUM_W'(1000);
  localparam logic [NUM_W-1:0]         ID_LOW_MAG    = NUM_W'(2000);
  localparam logic [DIV_CNT_W-1:0]     DIV_LAST_STEP = DIV_CNT_W'(NUM_W - 1);

  typedef struct packed {
    logic accum;
    logic mul;
    logic num;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] acc);
    return (acc == CNT_MAX) ? acc : acc + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add_gap(input logic [CNT_W-1:0] acc,
                                                   input logic [GAP_W-1:0] gap);
    logic [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(gap);
    return (s > SUM_W'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] acc);
    logic [CNT_W+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, acc};
    return t[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/alignment_identity_scorer.sv
// Top level of the alignment identity scorer: register port, controller and datapath.
//
// Each transfer carries one aligned base pair and is taken while the input is not stalled.
// The transfer that carries last_pair closes the alignment: the counts are frozen, the
// counters restart, and the input stalls while the identity is formed (a multiply step, a
// numerator step, the bit-serial divider, then the load of the result register). A waiting
// result does not hold the input once the result register is loaded; a second closing
// transfer waits only until that register frees.
`default_nettype none
module alignment_identity_scorer
  import asc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BASE_W-1:0]      query_base,
  input  logic [BASE_W-1:0]      target_base,
  input  logic                   target_masked,
  input  logic                   block_first,
  input  logic [GAP_W-1:0]       query_gap,
  input  logic [GAP_W-1:0]       target_gap,
  input  logic                   last_pair,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIELD_W-1:0]     match_total,
  output logic [FIELD_W-1:0]     mismatch_total,
  output logic [FIELD_W-1:0]     repeat_match_total,
  output logic [FIELD_W-1:0]     unknown_total,
  output logic [FIELD_W-1:0]     query_insert_count,
  output logic [FIELD_W-1:0]     query_insert_bases,
  output logic [FIELD_W-1:0]     target_insert_count,
  output logic [FIELD_W-1:0]     target_insert_bases,
  output logic signed [ID_W-1:0] identity_permille,
  output logic                   accepted
);

  logic [MG_W-1:0] min_good_percent;
  logic            cdna_mode;
  logic            wr_en;
  ctrl_cmd_t       cmd;
  dp_status_t      status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_good_percent <= MIN_GOOD_RESET;
      cdna_mode        <= 1'b0;
    end else if (wr_en) begin
      if (paddr == ADDR_MIN_GOOD) begin
        min_good_percent <= pwdata[MG_W-1:0];
      end
      if (paddr == ADDR_CDNA) begin
        cdna_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MIN_GOOD) begin
      prdata = APB_DATA_W'(min_good_percent);
    end else if (paddr == ADDR_CDNA) begin
      prdata = APB_DATA_W'(cdna_mode);
    end
  end

  asc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_pair (last_pair),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  asc_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .query_base          (query_base),
    .target_base         (target_base),
    .target_masked       (target_masked),
    .block_first         (block_first),
    .query_gap           (query_gap),
    .target_gap          (target_gap),
    .last_pair           (last_pair),
    .min_good_percent    (min_good_percent),
    .cdna_mode           (cdna_mode),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .match_total         (match_total),
    .mismatch_total      (mismatch_total),
    .repeat_match_total  (repeat_match_total),
    .unknown_total       (unknown_total),
    .query_insert_count  (query_insert_count),
    .query_insert_bases  (query_insert_bases),
    .target_insert_count (target_insert_count),
    .target_insert_bases (target_insert_bases),
    .identity_permille   (identity_permille),
    .accepted            (accepted)
  );

endmodule
`default_nettype wire

>>> hdl/asc_ctrl.sv
// Control state machine that sequences accumulation, identity division and result hand-off.
`default_nettype none
module asc_ctrl
  import asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       last_pair,
  input  dp_status_t status,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accum = in_valid;
        if (in_valid && last_pair) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (cmd.accum && last_pair) |=> in_stall)
    else $error("input not stalled after a closing transfer");
`endif

endmodule
`default_nettype wire

>>> hdl/asc_dpath.sv
// Datapath: saturating counters, identity numerator, bit-serial divider and result register.
`default_nettype none
module asc_dpath
  import asc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               status,
  input  logic [BASE_W-1:0]        query_base,
  input  logic [BASE_W-1:0]        target_base,
  input  logic                     target_masked,
  input  logic                     block_first,
  input  logic [GAP_W-1:0]         query_gap,
  input  logic [GAP_W-1:0]         target_gap,
  input  logic                     last_pair,
  input  logic [MG_W-1:0]          min_good_percent,
  input  logic                     cdna_mode,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FIELD_W-1:0]       match_total,
  output logic [FIELD_W-1:0]       mismatch_total,
  output logic [FIELD_W-1:0]       repeat_match_total,
  output logic [FIELD_W-1:0]       unknown_total,
  output logic [FIELD_W-1:0]       query_insert_count,
  output logic [FIELD_W-1:0]       query_insert_bases,
  output logic [FIELD_W-1:0]       target_insert_count,
  output logic [FIELD_W-1:0]       target_insert_bases,
  output logic signed [ID_W-1:0]   identity_permille,
  output logic                     accepted
);

  logic [CNT_W-1:0] match_acc, mismatch_acc, repeat_acc, unknown_acc;
  logic [CNT_W-1:0] qcnt_acc, qbases_acc, tcnt_acc, tbases_acc;
  logic [CNT_W-1:0] match_next, mismatch_next, repeat_next, unknown_next;
  logic [CNT_W-1:0] qcnt_next, qbases_next, tcnt_next, tbases_next;

  logic [CNT_W-1:0] snap_match, snap_mismatch, snap_repeat, snap_unknown;
  logic [CNT_W-1:0] snap_qcnt, snap_qbases, snap_tcnt, snap_tbases;

  logic is_unknown;
  logic is_equal;
  logic qgap_hit;
  logic tgap_hit;

  logic [GOOD_W-1:0]        good;
  logic [TOTAL_W-1:0]       total_next;
  logic [GAPS_W-1:0]        gaps;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod_q;
  logic [TOTAL_W-1:0]       total_q;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         mag;

  logic [NUM_W-1:0]     quo;
  logic [TOTAL_W-1:0]   rem;
  logic                 neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TOTAL_W:0]     rem_shift;
  logic [TOTAL_W:0]     rem_sub;

  logic                   total_nz;
  logic [ID_W-1:0]        id_mag;
  logic signed [ID_W-1:0] id_val;
  logic [THR_W-1:0]       thr;
  logic                   acc_flag;

  assign is_unknown = (query_base == BASE_UNKNOWN) || (target_base == BASE_UNKNOWN);
  assign is_equal   = (query_base == target_base);
  assign qgap_hit   = block_first && (query_gap != '0);
  assign tgap_hit   = block_first && (target_gap != '0);

  always_comb begin
    match_next    = (!is_unknown && is_equal && !target_masked) ? sat_inc(match_acc)
                                                                : match_acc;
    repeat_next   = (!is_unknown && is_equal && target_masked) ? sat_inc(repeat_acc)
                                                               : repeat_acc;
    mismatch_next = (!is_unknown && !is_equal) ? sat_inc(mismatch_acc) : mismatch_acc;
    unknown_next  = is_unknown ? sat_inc(unknown_acc) : unknown_acc;
    qcnt_next     = qgap_hit ? sat_inc(qcnt_acc) : qcnt_acc;
    qbases_next   = qgap_hit ? sat_add_gap(qbases_acc, query_gap) : qbases_acc;
    tcnt_next     = tgap_hit ? sat_inc(tcnt_acc) : tcnt_acc;
    tbases_next   = tgap_hit ? sat_add_gap(tbases_acc, target_gap) : tbases_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_acc    <= '0;
      mismatch_acc <= '0;
      repeat_acc   <= '0;
      unknown_acc  <= '0;
      qcnt_acc     <= '0;
      qbases_acc   <= '0;
      tcnt_acc     <= '0;
      tbases_acc   <= '0;
    end else if (cmd.accum) begin
      if (last_pair) begin
        match_acc    <= '0;
        mismatch_acc <= '0;
        repeat_acc   <= '0;
        unknown_acc  <= '0;
        qcnt_acc     <= '0;
        qbases_acc   <= '0;
        tcnt_acc     <= '0;
        tbases_acc   <= '0;
      end else begin
        match_acc    <= match_next;
        mismatch_acc <= mismatch_next;
        repeat_acc   <= repeat_next;
        unknown_acc  <= unknown_next;
        qcnt_acc     <= qcnt_next;
        qbases_acc   <= qbases_next;
        tcnt_acc     <= tcnt_next;
        tbases_acc   <= tbases_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && last_pair) begin
      snap_match    <= match_next;
      snap_mismatch <= mismatch_next;
      snap_repeat   <= repeat_next;
      snap_unknown  <= unknown_next;
      snap_qcnt     <= qcnt_next;
      snap_qbases   <= qbases_next;
      snap_tcnt     <= tcnt_next;
      snap_tbases   <= tbases_next;
    end
  end

  // The identity numerator is 1000 * (good - 2 * gaps) + total / 2.
  always_comb begin
    good       = GOOD_W'(snap_match) + GOOD_W'(snap_repeat);
    total_next = TOTAL_W'(good) + TOTAL_W'(snap_mismatch);
    gaps       = GAPS_W'(snap_qcnt) + (cdna_mode ? '0 : GAPS_W'(snap_tcnt));
    diff       = $signed({2'b00, good}) - $signed({1'b0, gaps, 1'b0});
    prod_next  = PROD_W'(diff) * PROD_W'(ID_SCALE);
    num        = NUM_W'(prod_q) + NUM_W'({1'b0, total_q[TOTAL_W-1:1]});
    mag        = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q  <= prod_next;
      total_q <= total_next;
    end
  end

  // Restoring division, one quotient bit per cycle.
  assign rem_shift = {rem, quo[NUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, total_q};

  always_ff @(posedge clk) begin
    if (cmd.num) begin
      quo     <= mag;
      rem     <= '0;
      neg     <= num[NUM_W-1];
      div_cnt <= DIV_LAST_STEP;
    end else if (cmd.step) begin
      if (!rem_sub[TOTAL_W]) begin
        rem <= rem_sub[TOTAL_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[TOTAL_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign status.div_done = (div_cnt == '0);
  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    total_nz = (total_q != '0);
    if (!total_nz) begin
      id_mag = '0;
      id_val = '0;
    end else if (neg) begin
      id_mag = (quo > ID_LOW_MAG) ? ID_LOW_MAG[ID_W-1:0] : quo[ID_W-1:0];
      id_val = $signed(ID_W'(0) - id_mag);
    end else begin
      id_mag = (quo > ID_HIGH_MAG) ? ID_HIGH_MAG[ID_W-1:0] : quo[ID_W-1:0];
      id_val = $signed(id_mag);
    end
    thr      = THR_W'({min_good_percent, 3'b000}) + THR_W'({min_good_percent, 1'b0});
    acc_flag = total_nz && ($signed({id_val[ID_W-1], id_val}) >= $signed({2'b00, thr}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      match_total         <= to_field(snap_match);
      mismatch_total      <= to_field(snap_mismatch);
      repeat_match_total  <= to_field(snap_repeat);
      unknown_total       <= to_field(snap_unknown);
      query_insert_count  <= to_field(snap_qcnt);
      query_insert_bases  <= to_field(snap_qbases);
      target_insert_count <= to_field(snap_tcnt);
      target_insert_bases <= to_field(snap_tbases);
      identity_permille   <= id_val;
      accepted            <= acc_flag;
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result register not loaded after finish");
  a_id_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (identity_permille >= -12'sd2000 && identity_permille <= 12'sd1000))
    else $error("identity outside its clamped range");
  a_accept_sign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> !identity_permille[ID_W-1])
    else $error("accepted alignment with negative identity");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.accum && last_pair) |=> (match_acc == '0 && unknown_acc == '0 && qcnt_acc == '0))
    else $error("counters not cleared after a closing transfer");
`endif

endmodule
`default_nettype wire
